// ===== sv/utf8_stream_decoder_macros.svh =====
// ============================================================================
// UTF-8 stream decoder assertion macros
// Shared assertion shorthands for the checker of the decoder's stream ports.
// ============================================================================
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define UTF8D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be seen outside reset.
`define UTF8D_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/utf8d_pkg.sv =====
// ============================================================================
// UTF-8 stream decoder package
// Types and byte-class constants shared by the decoder modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package utf8d_pkg;

    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CP_W        = 21;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_SKIP    = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_INVALID = 2'd1,
        ST_END     = 2'd2
    } status_t;

    // Byte classes.
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] STRAY_MAX  = 8'hC1;
    localparam logic [7:0] RESYNC_MIN = 8'hC0;
    localparam logic [7:0] RESYNC_MAX = 8'hFD;

    // Smallest legal value for each trail count, and the top of the code space.
    localparam logic [CP_W-1:0] MIN_CP_LEN1 = 21'h00080;
    localparam logic [CP_W-1:0] MIN_CP_LEN2 = 21'h00800;
    localparam logic [CP_W-1:0] MIN_CP_LEN3 = 21'h10000;
    localparam logic [CP_W-1:0] CP_MAX      = 21'h10FFFF;

    typedef struct packed {
        mode_t           mode;
        logic [1:0]      remaining;
        logic [1:0]      seq_len;
        logic [CP_W-1:0] acc;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
        logic            last;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] entry;
        logic [1:0]                count;
    } res_list_t;

endpackage

`default_nettype wire

// ===== sv/utf8d_decode.sv =====
// ============================================================================
// UTF-8 byte decode step
// Combinational next state and result list for one byte against the state.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module utf8d_decode
    import utf8d_pkg::*;
(
    input  dec_state_t state,
    input  logic [7:0] data_byte,
    input  logic       end_of_string,
    output dec_state_t state_next,
    output res_list_t  results
);

    mode_t           mode;
    logic            is_trail;
    logic [CP_W-1:0] acc_shift;
    logic [1:0]      rem_dec;
    logic [CP_W-1:0] min_cp;
    logic            bad_cp;
    logic            collect_trail;
    logic            collect_break;
    logic            resync;
    logic            go_examine;
    logic            is_single;
    logic            is_stray;
    logic            is_lead;
    logic            a_valid;
    logic            a_ok;
    logic            b_valid;
    logic            b_ok;
    result_t         res_a;
    result_t         res_b;
    result_t         res_end;

    // An unused mode code behaves as idle.
    assign mode = (state.mode == MODE_COLLECT || state.mode == MODE_SKIP) ?
                  state.mode : MODE_IDLE;

    assign is_trail  = (data_byte[7:6] == 2'b10);
    assign acc_shift = {state.acc[CP_W-7:0], data_byte[5:0]};
    assign rem_dec   = state.remaining - 2'd1;

    always_comb begin
        unique case (state.seq_len)
            2'd1:    min_cp = MIN_CP_LEN1;
            2'd2:    min_cp = MIN_CP_LEN2;
            default: min_cp = MIN_CP_LEN3;
        endcase
    end

    assign bad_cp        = (acc_shift < min_cp) || (acc_shift > CP_MAX);
    assign collect_trail = (mode == MODE_COLLECT) && is_trail;
    assign collect_break = (mode == MODE_COLLECT) && !is_trail;
    assign resync        = !data_byte[7] ||
                           (data_byte >= RESYNC_MIN && data_byte <= RESYNC_MAX);

    // A breaking byte is looked at again in skip mode.
    assign go_examine = !collect_trail &&
                        (!((mode == MODE_SKIP) || collect_break) || resync);

    assign is_single = !data_byte[7];
    assign is_stray  = data_byte[7] && (data_byte <= STRAY_MAX || data_byte > LEAD4_MAX);
    assign is_lead   = data_byte[7] && !is_stray;

    // Next state.
    always_comb begin
        state_next = state;
        state_next.mode = mode;
        if (collect_trail) begin
            state_next.acc       = acc_shift;
            state_next.remaining = rem_dec;
            if (rem_dec == 2'd0) begin
                state_next.mode = bad_cp ? MODE_SKIP : MODE_IDLE;
            end else if (end_of_string) begin
                state_next.mode = MODE_SKIP;
            end
        end
        if (collect_break) begin
            state_next.mode = MODE_SKIP;
        end
        if (go_examine) begin
            priority if (is_single) begin
                state_next.mode = MODE_IDLE;
            end else if (is_stray) begin
                state_next.mode = MODE_SKIP;
            end else begin
                state_next.mode = MODE_COLLECT;
                priority if (data_byte <= LEAD2_MAX) begin
                    state_next.acc     = {16'd0, data_byte[4:0]};
                    state_next.seq_len = 2'd1;
                end else if (data_byte <= LEAD3_MAX) begin
                    state_next.acc     = {17'd0, data_byte[3:0]};
                    state_next.seq_len = 2'd2;
                end else begin
                    state_next.acc     = {18'd0, data_byte[2:0]};
                    state_next.seq_len = 2'd3;
                end
                state_next.remaining = state_next.seq_len;
            end
        end
        if (end_of_string) begin
            state_next.mode      = MODE_IDLE;
            state_next.remaining = 2'd0;
            state_next.seq_len   = 2'd0;
            state_next.acc       = '0;
        end
    end

    // Results: one from the open sequence, one from the byte itself, then the end mark.
    assign a_valid = collect_break ||
                     (collect_trail && (rem_dec == 2'd0 || end_of_string));
    assign a_ok    = collect_trail && (rem_dec == 2'd0) && !bad_cp;
    assign b_valid = go_examine && (is_single || is_stray || (is_lead && end_of_string));
    assign b_ok    = go_examine && is_single;

    always_comb begin
        res_a.code_point = a_ok ? acc_shift : '0;
        res_a.status     = a_ok ? ST_VALID : ST_INVALID;
        res_a.last       = 1'b0;
        res_b.code_point = b_ok ? {13'd0, data_byte} : '0;
        res_b.status     = b_ok ? ST_VALID : ST_INVALID;
        res_b.last       = 1'b0;
        res_end.code_point = '0;
        res_end.status     = ST_END;
        res_end.last       = 1'b0;

        results.count = {1'b0, a_valid} + {1'b0, b_valid} + {1'b0, end_of_string};
        results.entry[0] = a_valid ? res_a : (b_valid ? res_b : res_end);
        results.entry[1] = (a_valid && b_valid) ? res_b : res_end;
        results.entry[2] = res_end;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            results.entry[k].last = (results.count == 2'(k + 1));
        end
    end

endmodule

`default_nettype wire

// ===== sv/utf8d_result_queue.sv =====
// ============================================================================
// UTF-8 decoder result queue
// Holds the results of one byte and hands them out one per request.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module utf8d_result_queue
    import utf8d_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  res_list_t load_list,
    input  logic      pop,
    output logic      free,
    output logic      head_valid,
    output result_t   head
);

    result_t [MAX_RESULTS-1:0] entry_reg;
    result_t [MAX_RESULTS-1:0] entry_next;
    logic [1:0]                count_reg;
    logic [1:0]                count_next;

    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[0];
    // Free for a new list once the last pending result leaves this cycle.
    assign free       = (count_reg == 2'd0) || ((count_reg == 2'd1) && pop);

    always_comb begin
        entry_next = entry_reg;
        count_next = count_reg;
        if (load) begin
            entry_next = load_list.entry;
            count_next = load_list.count;
        end else if (pop && head_valid) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                entry_next[k] = entry_reg[k + 1];
            end
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== sv/utf8_stream_decoder.sv =====
// ============================================================================
// UTF-8 stream decoder
// Decodes a byte stream into code points, invalid marks and end-of-string marks.
// ============================================================================
// One byte enters per request on the slave side; s_tlast marks the final byte
// of a string. Each byte gives zero to three results on the master side, in
// order: a result for the sequence it completes or breaks, a result for the
// byte itself, and an end mark after the final byte. m_tlast flags the last
// result of each byte. A byte with at most one result does not hold up the
// next byte while m_tready is high, so plain text streams at one byte per
// clock; a byte with more results keeps the next byte in the input register,
// as the queue gives one result per ready clock. Bytes that give no result
// (lead, middle trail and skipped bytes) pass even while the master side stalls.
// Overlong forms and values above 0x10FFFF are reported invalid; surrogates
// pass as valid. After an error, bytes are dropped until an ASCII byte or a
// byte in 0xC0..0xFD, which is then decoded afresh.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_string
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // last_result
);

    // Input register.
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic [7:0] in_byte_next;
    logic       in_eos_reg;
    logic       in_eos_next;

    // Decoder state.
    dec_state_t state_reg;
    dec_state_t state_dec;
    dec_state_t state_next;

    res_list_t  results;
    result_t    head;
    logic       q_free;
    logic       consume;
    logic       load;

    utf8d_decode u_decode (
        .state         (state_reg),
        .data_byte     (in_byte_reg),
        .end_of_string (in_eos_reg),
        .state_next    (state_dec),
        .results       (results)
    );

    // A byte with no results never waits on the result queue.
    assign consume  = in_valid_reg && (q_free || (results.count == 2'd0));
    assign load     = consume && (results.count != 2'd0);
    assign s_tready = !in_valid_reg || consume;

    utf8d_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .load_list  (results),
        .pop        (m_tready),
        .free       (q_free),
        .head_valid (m_tvalid),
        .head       (head)
    );

    assign m_tdata = {3'd0, head.code_point};
    assign m_tuser = head.status;
    assign m_tlast = head.last;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_eos_next   = in_eos_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_eos_next   = s_tlast;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
        state_next = consume ? state_dec : state_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= '{mode: MODE_IDLE, remaining: 2'd0, seq_len: 2'd0, acc: '0};
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
        in_byte_reg <= in_byte_next;
        in_eos_reg  <= in_eos_next;
    end

endmodule

`default_nettype wire

// ===== sv/utf8d_checker.sv =====
// ============================================================================
// UTF-8 stream decoder checker
// Port-level assertions on the result stream, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_macros.svh"

module utf8d_checker
    import utf8d_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // A stalled result keeps its status.
    `UTF8D_ASSERT(a_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)), "stalled result changed")
    // Only a valid status carries a code point.
    `UTF8D_ASSERT(a_cp_zero, aclk, aresetn, (m_tvalid && m_tuser != ST_VALID) |-> (m_tdata == 24'd0), "code point on non-valid result")
    // The end mark is always the final result of its byte.
    `UTF8D_ASSERT(a_end_last, aclk, aresetn, (m_tvalid && m_tuser == ST_END) |-> m_tlast, "end mark not last")
    // Decoded code points stay inside the code space.
    `UTF8D_ASSERT_NEVER(a_cp_range, aclk, aresetn, m_tvalid && (m_tdata > 24'h10FFFF), "code point out of range")

endmodule

bind utf8_stream_decoder utf8d_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== dv/tb_utf8_stream_decoder.sv =====
// ============================================================================
// UTF-8 stream decoder testbench
// Streams directed and random byte strings into the decoder with random gaps
// on the input side and random stalls on the result side. A scoreboard
// predicts each byte's results and checks every result that is taken.
// ============================================================================
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
    import utf8d_pkg::*;

    localparam int RANDOM_BYTES = 130;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam logic [7:0] ASCII_MAX = 8'h7F;

    // Predicts the results of each accepted byte and checks the results
    // that leave the decoder, oldest first.
    class utf8_result_board;
        mode_t           mode;
        logic [1:0]      remaining;
        logic [1:0]      seq_len;
        logic [CP_W-1:0] acc;
        result_t         awaited[$];
        int              errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode      = MODE_IDLE;
            remaining = 2'd0;
            seq_len   = 2'd0;
            acc       = '0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void add_result(logic [CP_W-1:0] cp, status_t st);
            result_t r;
            r.code_point = (st == ST_VALID) ? cp : '0;
            r.status     = st;
            r.last       = 1'b0;
            awaited = {awaited, r};
        endfunction

        function logic [CP_W-1:0] min_value(logic [1:0] len);
            case (len)
                2'd1:    return MIN_CP_LEN1;
                2'd2:    return MIN_CP_LEN2;
                default: return MIN_CP_LEN3;
            endcase
        endfunction

        function void start_from_idle(logic [7:0] b);
            if (b <= ASCII_MAX) begin
                add_result({13'd0, b}, ST_VALID);
                mode = MODE_IDLE;
            end else if (b <= STRAY_MAX || b > LEAD4_MAX) begin
                add_result('0, ST_INVALID);
                mode = MODE_SKIP;
            end else begin
                if (b <= LEAD2_MAX) begin
                    acc     = {16'd0, b[4:0]};
                    seq_len = 2'd1;
                end else if (b <= LEAD3_MAX) begin
                    acc     = {17'd0, b[3:0]};
                    seq_len = 2'd2;
                end else begin
                    acc     = {18'd0, b[2:0]};
                    seq_len = 2'd3;
                end
                remaining = seq_len;
                mode      = MODE_COLLECT;
            end
        endfunction

        // Works out the results of one accepted byte.
        function void decode_byte(logic [7:0] b, logic eos);
            int      count_at_entry;
            logic    taken;
            count_at_entry = awaited.size();
            taken = 1'b0;
            if (mode == MODE_COLLECT) begin
                if (b[7:6] == 2'b10) begin
                    acc       = {acc[CP_W-7:0], b[5:0]};
                    remaining = remaining - 2'd1;
                    if (remaining == 2'd0) begin
                        if (acc < min_value(seq_len) || acc > CP_MAX) begin
                            add_result('0, ST_INVALID);
                            mode = MODE_SKIP;
                        end else begin
                            add_result(acc, ST_VALID);
                            mode = MODE_IDLE;
                        end
                    end else if (eos) begin
                        add_result('0, ST_INVALID);
                        mode = MODE_SKIP;
                    end
                    taken = 1'b1;
                end else begin
                    // The breaking byte falls through to the skip check below.
                    add_result('0, ST_INVALID);
                    mode = MODE_SKIP;
                end
            end
            if (!taken && mode == MODE_SKIP) begin
                if (b <= ASCII_MAX || (b >= RESYNC_MIN && b <= RESYNC_MAX))
                    mode = MODE_IDLE;
                else
                    taken = 1'b1;
            end
            if (!taken) begin
                start_from_idle(b);
                if (eos && mode == MODE_COLLECT)
                    add_result('0, ST_INVALID);
            end
            if (eos) begin
                add_result('0, ST_END);
                clear_state();
            end
            if (awaited.size() > count_at_entry)
                awaited[awaited.size() - 1].last = 1'b1;
        endfunction

        function void check_result(logic [CP_W-1:0] cp, logic [1:0] st, logic lst,
                                   logic [2:0] pad);
            result_t want;
            if (awaited.size() == 0) begin
                $error("result with nothing awaited: code_point=%h status=%0d last=%0b",
                       cp, st, lst);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (cp !== want.code_point) begin
                $error("code_point: expected %h, actual %h", want.code_point, cp);
                errors++;
            end
            if (st !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (lst !== want.last) begin
                $error("last_result: expected %0b, actual %0b", want.last, lst);
                errors++;
            end
            if (pad !== 3'd0) begin
                $error("m_tdata padding: expected 0, actual %0h", pad);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    utf8_result_board board;
    logic [7:0]       str_q[$];
    bit               calm_in;
    bit               calm_out;
    int               random_sent;

    utf8_stream_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Every so often a side switches into or out of a stretch with no waits.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 19) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    // Both requests are sampled in one process, the input first, so a result
    // can never be checked before the byte that caused it has been predicted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata[CP_W-1:0], m_tuser, m_tlast, m_tdata[23:21]);
        end
    end

    // Result side: a random stall before each result.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = draw_wait(calm_out);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_byte(logic [7:0] b, logic eos);
        int gap;
        gap = draw_wait(calm_in);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++)
            send_byte(str_q[i], i == str_q.size() - 1);
    endtask

    function automatic logic [7:0] trail_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic void append_byte(logic [7:0] b);
        str_q = {str_q, b};
    endfunction

    // Appends one unit to the string: mostly full-length sequences with
    // random payload, the rest noise, cut-short sequences and bad leads.
    function automatic void add_unit();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            len = $urandom_range(1, 4);
            case (len)
                1: append_byte(8'($urandom_range(0, 127)));
                2: append_byte(8'($urandom_range(8'hC2, 8'hDF)));
                3: append_byte(8'($urandom_range(8'hE0, 8'hEF)));
                default: append_byte(8'($urandom_range(8'hF0, 8'hF4)));
            endcase
            for (int i = 1; i < len; i++)
                append_byte(trail_byte());
        end else if (kind < 85) begin
            append_byte(8'($urandom_range(0, 255)));
        end else if (kind < 93) begin
            len = $urandom_range(3, 4);
            append_byte(len == 3 ? 8'($urandom_range(8'hE0, 8'hEF))
                                 : 8'($urandom_range(8'hF0, 8'hF4)));
            len = $urandom_range(0, len - 2);
            for (int i = 0; i < len; i++)
                append_byte(trail_byte());
        end else begin
            // Overlong two-byte leads and bytes above the last lead.
            if ($urandom_range(0, 1) == 0)
                append_byte(8'($urandom_range(8'hC0, 8'hC1)));
            else
                append_byte(8'($urandom_range(8'hF5, 8'hFF)));
            append_byte(trail_byte());
        end
    endfunction

    initial begin
        int units;
        board       = new();
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        random_sent = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // ASCII extremes, the largest two-byte value, an overlong three-byte
        // form followed by a swallowed trail, a four-byte value above the code
        // space, a stray lead, a broken sequence whose breaking byte decodes
        // by itself, the top of the code space, a stray byte, a skipped byte,
        // and a lead that the end of the string cuts short.
        str_q = '{8'h00, 8'h7F, 8'hDF, 8'hBF, 8'hE0, 8'h80, 8'h80, 8'h80,
                  8'hF4, 8'h90, 8'h80, 8'h80, 8'hC0, 8'hE2, 8'h41,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hFF, 8'hFE, 8'hC2};
        send_string();
        // Broken sequence on the final byte: invalid, the byte, then the end.
        str_q = '{8'hE2, 8'h82, 8'h41};
        send_string();

        while (random_sent < RANDOM_BYTES) begin
            str_q.delete();
            units = $urandom_range(1, 6);
            for (int i = 0; i < units; i++)
                add_unit();
            random_sent += str_q.size();
            send_string();
        end
        s_tvalid <= 1'b0;

        while (board.pending() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
